// ===== src/fsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsbc_pkg
// Shared types and constants of the fan speed button controller: request and
// response payload structs, command codes and the percent-to-duty mapping.
// ----------------------------------------------------------------------------
package fsbc_pkg;

   // number of fan slots carried on the response
   localparam int unsigned SLOTS = 4;

   // command codes
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_SET_ONE = 2'd1;
   localparam logic [1:0] CMD_SET_ALL = 2'd2;

   // speed arithmetic
   localparam logic [6:0]  STEP_PCT  = 7'd25;
   localparam logic [6:0]  TOP_PCT   = 7'd100;
   localparam logic [6:0]  INC_LIMIT = 7'd75;
   localparam logic [7:0]  TOP_PCT_8 = 8'd100;

   // debounce counter ceiling
   localparam logic [15:0] TICK_MAX = 16'hFFFF;

   // button bit positions in the level vector
   localparam int unsigned BTN_DEC = 0;
   localparam int unsigned BTN_INC = 1;
   localparam int unsigned BTN_TGL = 2;

   // x/100 as x*5243 >> 19, exact for x up to 255*100
   localparam logic [12:0] RECIP_100  = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] fan_index;
      logic [7:0] percent;
      logic       decrease_level;
      logic       increase_level;
      logic       toggle_level;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] duty0;
      logic [7:0] duty1;
      logic [7:0] duty2;
      logic [7:0] duty3;
      logic [6:0] speed0;
      logic [6:0] speed1;
      logic [6:0] speed2;
      logic [6:0] speed3;
      logic       save_request;
   } rsp_payload_type;

   // speed * 255 / 100, speed in 0..100
   function automatic logic [7:0] pct_to_duty(input logic [6:0] spd);
      logic [14:0] scaled;
      logic [27:0] prod;
      scaled = {spd, 8'b0} - 15'(spd);
      prod   = 28'(scaled) * 28'(RECIP_100);
      return prod[RECIP_SHIFT +: 8];
   endfunction

endpackage

// ===== src/fan_speed_button_controller_unit.sv =====
// ----------------------------------------------------------------------------
// fan_speed_button_controller_unit
// Keeps a speed percent per fan, driven by debounced button ticks and
// set-one / set-all commands, and reports speeds, PWM duties and a save flag.
// ----------------------------------------------------------------------------
//  channel    | ports                            | moves
//  -----------+----------------------------------+-------------------------
//  request    | req_valid, req_stall, req_data   | tick or set command in
//  response   | rsp_valid, rsp_stall, rsp_data   | speeds, duties, save flag
//  csr        | csr_wr_en, csr_wr_data           | debounce interval write
//
//  one request per cycle sustained while the response is not stalled; a request
//  passes the input register, then the response register, the speed update sitting between the two.
//  synchronous active-high reset clears speeds to 0, button history to
//  released, the debounce counter to 0 and the debounce interval to 50.
//  a stalled response holds the input register, which then stalls requests.
// ----------------------------------------------------------------------------
module fan_speed_button_controller_unit
   import fsbc_pkg::*;
#(
   parameter int unsigned NUM_FANS = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data
);

   localparam logic [2:0] NumFansIdx = 3'(NUM_FANS);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic [6:0]      speed_ff [SLOTS];
   logic [6:0]      speed_in [SLOTS];
   logic [2:0]      last_lvl_ff, last_lvl_in;
   logic [15:0]     tick_cnt_ff, tick_cnt_in;
   logic [15:0]     debounce_ff, debounce_in;
   logic            advance;
   logic            save;

   // handshake: input register moves on when the response register frees up
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);
   assign debounce_in = csr_wr_en ? csr_wr_data : debounce_ff;

   // speed and debounce update for the item in the input register
   always_comb begin
      logic [15:0] cnt_inc;
      logic [2:0]  now_lvl;
      logic [2:0]  fell;
      logic [6:0]  stage [SLOTS];
      logic [6:0]  pct;
      logic        any_on;
      speed_in    = speed_ff;
      last_lvl_in = last_lvl_ff;
      tick_cnt_in = tick_cnt_ff;
      save        = 1'b0;
      cnt_inc     = (tick_cnt_ff == TICK_MAX) ? tick_cnt_ff : tick_cnt_ff + 16'd1;
      now_lvl     = {in_data_ff.toggle_level, in_data_ff.increase_level,
                     in_data_ff.decrease_level};
      fell        = last_lvl_ff & ~now_lvl;
      pct         = (in_data_ff.percent > TOP_PCT_8) ? TOP_PCT : in_data_ff.percent[6:0];
      stage       = speed_ff;
      any_on      = 1'b0;
      if (advance) begin
         case (in_data_ff.command)
            CMD_TICK: begin
               if (cnt_inc >= debounce_ff) begin
                  tick_cnt_in = '0;
                  last_lvl_in = now_lvl;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (i < NUM_FANS) begin
                        if (fell[BTN_DEC])
                           stage[i] = (stage[i] >= STEP_PCT) ? stage[i] - STEP_PCT : '0;
                        if (fell[BTN_INC])
                           stage[i] = (stage[i] <= INC_LIMIT) ? stage[i] + STEP_PCT : TOP_PCT;
                        any_on = any_on || (stage[i] != '0);
                     end
                  end
                  for (int i = 0; i < SLOTS; i++) begin
                     if (i < NUM_FANS && fell[BTN_TGL])
                        stage[i] = any_on ? '0 : TOP_PCT;
                  end
                  speed_in = stage;
                  save     = |fell;
               end else begin
                  tick_cnt_in = cnt_inc;
               end
            end
            CMD_SET_ONE: begin
               if (in_data_ff.fan_index < NumFansIdx) begin
                  speed_in[in_data_ff.fan_index[1:0]] = pct;
                  save = 1'b1;
               end
            end
            CMD_SET_ALL: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (i < NUM_FANS)
                     speed_in[i] = pct;
               end
               save = 1'b1;
            end
            default: begin
               save = 1'b0;
            end
         endcase
      end
   end

   // response payload from the updated speeds
   always_comb begin
      out_data_in.speed0       = speed_in[0];
      out_data_in.speed1       = speed_in[1];
      out_data_in.speed2       = speed_in[2];
      out_data_in.speed3       = speed_in[3];
      out_data_in.duty0        = pct_to_duty(speed_in[0]);
      out_data_in.duty1        = pct_to_duty(speed_in[1]);
      out_data_in.duty2        = pct_to_duty(speed_in[2]);
      out_data_in.duty3        = pct_to_duty(speed_in[3]);
      out_data_in.save_request = save;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_lvl_ff  <= 3'b111;
         tick_cnt_ff  <= '0;
         debounce_ff  <= 16'd50;
         for (int i = 0; i < SLOTS; i++)
            speed_ff[i] <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         last_lvl_ff  <= last_lvl_in;
         tick_cnt_ff  <= tick_cnt_in;
         debounce_ff  <= debounce_in;
         speed_ff     <= speed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall)
         in_data_ff <= req_data;
      if (advance)
         out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== src/fsbc_checker.sv =====
// ----------------------------------------------------------------------------
// fsbc_checker
// Port-level checks of the fan speed button controller, bound to the top.
// ----------------------------------------------------------------------------
module fsbc_checker
   import fsbc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // every accepted request is followed by a valid response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("accepted request produced no response");

   // speeds never leave the percent range
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.speed0 <= TOP_PCT && rsp_data.speed1 <= TOP_PCT &&
                    rsp_data.speed2 <= TOP_PCT && rsp_data.speed3 <= TOP_PCT)
      else $error("speed above 100 percent");

   // duty end points of fan 0 follow its speed
   a_duty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.speed0 == TOP_PCT) == (rsp_data.duty0 == 8'd255) &&
                    (rsp_data.speed0 == '0) == (rsp_data.duty0 == 8'd0))
      else $error("duty does not match speed at an end point");

   // set-all of 100 percent or more, moving on with no stall downstream, writes full speed to fan 0
   a_set_all: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.command == CMD_SET_ALL &&
      req_data.percent >= TOP_PCT_8 ##1 !rsp_stall
      |=> rsp_data.save_request && rsp_data.speed0 == TOP_PCT)
      else $error("set-all did not write full speed");

endmodule

bind fan_speed_button_controller_unit fsbc_checker u_fsbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
